// ----- rtl/double_ended_queue_core_defines.svh -----
// Assertion macros shared by the deque core RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
// Deque core package: sizes, operation and status codes, word and control types.
// Depends on nothing; used by every module of the deque core but deq_ram.
package deq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = 7;
  localparam int SUM_W = CNT_W + 1;
  localparam int DATA_W = 32;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_DUMP       = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               operation;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] item_value;
    logic [CNT_W-1:0]         entry_count;
    logic [1:0]               status;
    logic                     last_result;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic dump_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic dump_go;
    logic dump_last;
  } dp_stat_t;

endpackage

// ----- rtl/deq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the deque entries.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/deq_ctrl.sv -----
// Deque controller: sequences accept, execute and dump streaming.
// Depends on deq_pkg; drives commands into deq_dp.
module deq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  deq_pkg::dp_stat_t    stat,
  output deq_pkg::ctrl_cmd_t   cmd,
  output logic                 busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = stat.dump_go ? S_DUMP : S_IDLE;
      end
      S_DUMP: begin
        cmd.dump_step = 1'b1;
        if (stat.dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/deq_dp.sv -----
// Deque datapath: ring pointers, entry RAM and registered result word.
// Depends on deq_pkg and deq_ram; commanded by deq_ctrl.
module deq_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  deq_pkg::ctrl_cmd_t   cmd,
  input  deq_pkg::in_word_t    in_word,
  output deq_pkg::dp_stat_t    stat,
  output logic                 out_strobe,
  output deq_pkg::out_word_t   out_word
);

  logic [2:0]                      op_r;
  logic [deq_pkg::DATA_W-1:0]      val_r;
  logic [deq_pkg::IDX_W-1:0]       front_r, front_nxt;
  logic [deq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [deq_pkg::IDX_W-1:0]       ptr_r, ptr_nxt;
  logic [deq_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  deq_pkg::out_word_t              out_word_r, out_word_nxt;

  logic [deq_pkg::IDX_W-1:0]       front_inc, front_dec, ptr_inc, back_addr;
  logic [deq_pkg::SUM_W-1:0]       back_sum;
  logic                            full, empty, emit;
  logic [1:0]                      status_v;
  logic                            wr_en;
  logic [deq_pkg::IDX_W-1:0]       wr_addr, rd_addr;
  logic [deq_pkg::DATA_W-1:0]      rd_data;

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign full  = (count_r == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (count_r == '0);

  assign front_inc = (front_r == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1) : front_r - 1'b1;
  assign ptr_inc   = (ptr_r == deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign back_sum  = deq_pkg::SUM_W'(front_r) + deq_pkg::SUM_W'(count_r);
  assign back_addr = (back_sum >= deq_pkg::SUM_W'(deq_pkg::DEPTH))
                   ? deq_pkg::IDX_W'(back_sum - deq_pkg::SUM_W'(deq_pkg::DEPTH))
                   : deq_pkg::IDX_W'(back_sum);

  always_comb begin
    front_nxt      = front_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rem_nxt        = rem_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    wr_en          = 1'b0;
    wr_addr        = back_addr;
    rd_addr        = ptr_r;
    status_v       = deq_pkg::ST_OK;
    emit           = 1'b0;

    if (cmd.exec) begin
      emit    = 1'b1;
      rd_addr = front_r;
      case (op_r)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_v = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = front_dec;
            front_nxt = front_dec;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_v = deq_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_v = deq_pkg::ST_EMPTY;
          end else begin
            front_nxt = front_inc;
            count_nxt = count_r - 1'b1;
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_v = deq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
          end
        end
        deq_pkg::OP_DUMP: begin
          if (empty) begin
            status_v = deq_pkg::ST_EMPTY;
          end else begin
            emit    = 1'b0;
            ptr_nxt = front_inc;
            rem_nxt = count_r;
          end
        end
        default: begin
          status_v = deq_pkg::ST_OK;
        end
      endcase
      if (emit) begin
        out_strobe_nxt           = 1'b1;
        out_word_nxt.item_value  = '0;
        out_word_nxt.entry_count = count_nxt;
        out_word_nxt.status      = status_v;
        out_word_nxt.last_result = 1'b1;
      end
    end else if (cmd.dump_step) begin
      // stream one entry, prefetch the next slot
      out_strobe_nxt           = 1'b1;
      out_word_nxt.item_value  = $signed(rd_data);
      out_word_nxt.entry_count = count_r;
      out_word_nxt.status      = deq_pkg::ST_OK;
      out_word_nxt.last_result = stat.dump_last;
      ptr_nxt                  = ptr_inc;
      rem_nxt                  = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_word.operation;
      val_r <= in_word.push_value;
    end
    ptr_r      <= ptr_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      count_r      <= '0;
      rem_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      front_r      <= front_nxt;
      count_r      <= count_nxt;
      rem_r        <= rem_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  assign stat.dump_go   = (op_r == deq_pkg::OP_DUMP) && !empty;
  assign stat.dump_last = (rem_r == deq_pkg::CNT_W'(1));
  assign out_strobe     = out_strobe_r;
  assign out_word       = out_word_r;

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// Double-ended queue of signed 32-bit words in a 64-entry ring RAM. A word is
// taken when start is high and busy is low; busy then stays high for one cycle
// on push, pop and undefined operations, and their single result strobes on
// out_strobe in the cycle after that, so the next such word is taken only
// after busy falls. A dump of N stored entries keeps busy high through the
// execute and dump states and delivers N results on consecutive cycles, one
// RAM read per cycle, the last marked by last_result; an empty dump gives one
// empty-status result. Each result is valid for exactly one cycle and cannot be
// held off: the receiver must capture every cycle in which out_strobe is high.
// Depends on deq_pkg, deq_ctrl, deq_dp, deq_ram and the core defines header.
`include "double_ended_queue_core_defines.svh"

module double_ended_queue_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  deq_pkg::in_word_t   in_word,
  output logic                out_strobe,
  output deq_pkg::out_word_t  out_word
);

  deq_pkg::ctrl_cmd_t cmd;
  deq_pkg::dp_stat_t  stat;

  deq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  deq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  `DEQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_strobe, "accept must enter execute with no result pending")
  `DEQ_ASSERT_NOW(a_last_idle, clk, rst_n, out_strobe && out_word.last_result, !busy, "final result must coincide with idle")
  `DEQ_ASSERT_NEXT(a_dump_stream, clk, rst_n, out_strobe && !out_word.last_result, out_strobe, "dump stream must not gap")
  `DEQ_ASSERT_NOW(a_count_range, clk, rst_n, out_strobe, out_word.entry_count <= 7'(deq_pkg::DEPTH), "entry count beyond depth")

endmodule

// ----- test/tb_double_ended_queue_core.sv -----
`timescale 1ns / 1ps
// Testbench for double_ended_queue_core: directed table, fill to full, random operations.
// Checks results against table words or a local predictor. Depends on deq_pkg and core RTL.
module tb_double_ended_queue_core;
  import deq_pkg::*;

  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_word_t  in_word;
  logic      out_strobe;
  out_word_t out_word;

  logic signed [DATA_W-1:0] mdl_store [DEPTH];
  int        mdl_front;
  int        mdl_count;
  out_word_t predicted[$];
  out_word_t awaited_words[$];
  stim_row_t dir_table[$];
  out_word_t want_word;
  int        errors;
  int        idle_pct;
  int        cycle_count;

  double_ended_queue_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic out_word_t mk_out(logic signed [DATA_W-1:0] value, int count,
                                       logic [1:0] status, logic last);
    out_word_t r;
    r.item_value  = value;
    r.entry_count = count[CNT_W-1:0];
    r.status      = status;
    r.last_result = last;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic signed [DATA_W-1:0] value,
                                  logic typed, out_word_t want);
    stim_row_t r;
    r.word.operation  = op;
    r.word.push_value = value;
    r.typed           = typed;
    r.want            = want;
    dir_table.push_back(r);
  endfunction

  function automatic void deque_step(in_word_t w);
    logic [1:0] st;
    st = ST_OK;
    case (w.operation)
      OP_PUSH_FRONT: begin
        if (mdl_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          mdl_front = (mdl_front + DEPTH - 1) % DEPTH;
          mdl_store[mdl_front] = w.push_value;
          mdl_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (mdl_count >= DEPTH) begin
          st = ST_FULL;
        end else begin
          mdl_store[(mdl_front + mdl_count) % DEPTH] = w.push_value;
          mdl_count++;
        end
      end
      OP_POP_FRONT: begin
        if (mdl_count == 0) begin
          st = ST_EMPTY;
        end else begin
          mdl_front = (mdl_front + 1) % DEPTH;
          mdl_count--;
        end
      end
      OP_POP_BACK: begin
        if (mdl_count == 0) st = ST_EMPTY;
        else mdl_count--;
      end
      OP_DUMP: begin
        if (mdl_count == 0) begin
          st = ST_EMPTY;
        end else begin
          for (int k = 0; k < mdl_count; k++)
            predicted.push_back(mk_out(mdl_store[(mdl_front + k) % DEPTH], mdl_count, ST_OK,
                                       k == mdl_count - 1));
          return;
        end
      end
      default: ;
    endcase
    predicted.push_back(mk_out('0, mdl_count, st, 1'b1));
  endfunction

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    deque_step(w);
    if (typed) begin
      predicted.delete();
      awaited_words.push_back(want);
    end else begin
      while (predicted.size() != 0) awaited_words.push_back(predicted.pop_front());
    end
  endtask

  task automatic run_random(int n, int push_pct);
    in_word_t w;
    int       r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      w.push_value = $urandom;
      if (r < push_pct) w.operation = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else if (r < 80) w.operation = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      else if (r < 92) w.operation = OP_DUMP;
      else w.operation = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
      send_word(w, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (awaited_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word value %0d count %0d status %0d last %0b", $time,
                 out_word.item_value, out_word.entry_count, out_word.status,
                 out_word.last_result);
      end else begin
        want_word = awaited_words.pop_front();
        if (out_word.item_value !== want_word.item_value) begin
          errors++;
          $display("%0t: item_value expected %0d got %0d", $time,
                   want_word.item_value, out_word.item_value);
        end
        if (out_word.entry_count !== want_word.entry_count) begin
          errors++;
          $display("%0t: entry_count expected %0d got %0d", $time,
                   want_word.entry_count, out_word.entry_count);
        end
        if (out_word.status !== want_word.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time,
                   want_word.status, out_word.status);
        end
        if (out_word.last_result !== want_word.last_result) begin
          errors++;
          $display("%0t: last_result expected %0b got %0b", $time,
                   want_word.last_result, out_word.last_result);
        end
      end
    end
  end

  initial begin
    in_word_t w;
    errors    = 0;
    mdl_front = 0;
    mdl_count = 0;
    idle_pct  = 24;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;

    add_row(OP_POP_FRONT,  32'sd0,          1'b1, mk_out('0, 0, ST_EMPTY, 1'b1));
    add_row(OP_POP_BACK,   -32'sd1,         1'b1, mk_out('0, 0, ST_EMPTY, 1'b1));
    add_row(OP_DUMP,       32'sd0,          1'b1, mk_out('0, 0, ST_EMPTY, 1'b1));
    add_row(OP_RSVD5,      32'sd0,          1'b1, mk_out('0, 0, ST_OK, 1'b1));
    add_row(OP_RSVD6,      32'sh7FFFFFFF,   1'b1, mk_out('0, 0, ST_OK, 1'b1));
    add_row(OP_RSVD7,      32'sh80000000,   1'b1, mk_out('0, 0, ST_OK, 1'b1));
    add_row(OP_PUSH_FRONT, 32'sh7FFFFFFF,   1'b1, mk_out('0, 1, ST_OK, 1'b1));
    add_row(OP_PUSH_BACK,  32'sh80000000,   1'b1, mk_out('0, 2, ST_OK, 1'b1));
    add_row(OP_PUSH_FRONT, -32'sd1,         1'b1, mk_out('0, 3, ST_OK, 1'b1));
    add_row(OP_PUSH_BACK,  32'sd0,          1'b1, mk_out('0, 4, ST_OK, 1'b1));
    add_row(OP_PUSH_BACK,  32'sd1,          1'b1, mk_out('0, 5, ST_OK, 1'b1));
    add_row(OP_DUMP,       32'sd0,          1'b0, '0);
    add_row(OP_POP_FRONT,  32'sd0,          1'b1, mk_out('0, 4, ST_OK, 1'b1));
    add_row(OP_POP_BACK,   32'sd0,          1'b1, mk_out('0, 3, ST_OK, 1'b1));
    add_row(OP_RSVD7,      -32'sd1,         1'b1, mk_out('0, 3, ST_OK, 1'b1));
    add_row(OP_DUMP,       32'sh12345678,   1'b0, '0);
    add_row(OP_POP_BACK,   32'sd0,          1'b1, mk_out('0, 2, ST_OK, 1'b1));
    add_row(OP_POP_BACK,   32'sd0,          1'b1, mk_out('0, 1, ST_OK, 1'b1));
    add_row(OP_POP_FRONT,  32'sd0,          1'b1, mk_out('0, 0, ST_OK, 1'b1));
    add_row(OP_POP_FRONT,  32'sd0,          1'b1, mk_out('0, 0, ST_EMPTY, 1'b1));
    add_row(OP_PUSH_BACK,  32'shAAAAAAAA,   1'b1, mk_out('0, 1, ST_OK, 1'b1));
    add_row(OP_PUSH_FRONT, 32'sh55555555,   1'b1, mk_out('0, 2, ST_OK, 1'b1));
    add_row(OP_DUMP,       32'sd0,          1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) send_word(dir_table[i].word, dir_table[i].typed, dir_table[i].want);

    while (mdl_count < DEPTH) begin
      w.operation  = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      w.push_value = $urandom;
      send_word(w, 1'b0, '0);
    end
    w.push_value = $urandom;
    w.operation  = OP_PUSH_FRONT;
    send_word(w, 1'b1, mk_out('0, DEPTH, ST_FULL, 1'b1));
    w.operation  = OP_PUSH_BACK;
    send_word(w, 1'b1, mk_out('0, DEPTH, ST_FULL, 1'b1));
    w.operation  = OP_DUMP;
    send_word(w, 1'b0, '0);
    w.operation  = OP_RSVD5;
    send_word(w, 1'b1, mk_out('0, DEPTH, ST_OK, 1'b1));

    idle_pct = 47;
    run_random(20, 30);
    idle_pct = 0;
    run_random(20, 55);
    start <= 1'b0;

    while (awaited_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/double_ended_queue_core.sv
test/tb_double_ended_queue_core.sv
